[rtl/core/rmug_pkg.sv]
// ----------------------------------------------------------------------------
// rmug_pkg: shared definitions for the random matching union generator
// Holds the field widths, the configuration register indexes, the divider
// step constants and the command and status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package rmug_pkg;

  localparam int DEFAULT_MAX_NODES  = 64;
  localparam int DEFAULT_MAX_ROUNDS = 15;

  localparam int WORD_W        = 32;
  localparam int NODE_FIELD_W  = 6;
  localparam int EDGE_FIELD_W  = 9;
  localparam int ROUND_FIELD_W = 4;
  localparam int NODE_CFG_W    = 7;
  localparam int ROUND_CFG_W   = 4;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = 7;

  localparam logic [CFG_INDEX_W-1:0] REG_NODE_COUNT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_ROUND_COUNT = 1'b1;

  // The remainder unit retires this many dividend bits per cycle.
  localparam int DIV_BITS_PER_CYCLE = 8;
  localparam int DIV_CYCLES         = WORD_W / DIV_BITS_PER_CYCLE;

  typedef struct packed {
    logic accept;
    logic swap_rd;
    logic swap_wr_first;
    logic swap_wr_second;
    logic pair_rd;
    logic pair_load;
    logic odd_load;
  } rmug_cmd_t;

  typedef struct packed {
    logic div_done;
    logic odd_pending;
    logic last_step;
    logic last_pair;
    logic out_free;
  } rmug_status_t;

  // Node values are at most 8 bits wide; the result field keeps the low bits.
  function automatic logic [NODE_FIELD_W-1:0] node_field(input logic [7:0] v);
    return v[NODE_FIELD_W-1:0];
  endfunction

  function automatic logic [ROUND_FIELD_W-1:0] round_field(input logic [7:0] v);
    return v[ROUND_FIELD_W-1:0];
  endfunction

endpackage

[rtl/core/rmug_divider.sv]
// ----------------------------------------------------------------------------
// rmug_divider: multi-cycle remainder unit
// Computes a 32-bit dividend modulo a narrow divisor, retiring a fixed number
// of dividend bits per cycle by restoring subtraction.
// ----------------------------------------------------------------------------
module rmug_divider
  import rmug_pkg::*;
#(
  parameter int DW = 7
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [WORD_W-1:0] dividend,
  input  logic [DW-1:0]     divisor,
  output logic              done,
  output logic [DW-1:0]     remainder
);

  localparam int CW = $clog2(DIV_CYCLES);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [WORD_W-1:0] shift;
  logic [DW-1:0]     dsor;
  logic [DW-1:0]     rem;
  logic [WORD_W-1:0] shift_next;
  logic [DW-1:0]     rem_next;

  always_comb begin
    logic [DW:0] trial;
    trial      = '0;
    shift_next = shift;
    rem_next   = rem;
    for (int k = 0; k < DIV_BITS_PER_CYCLE; k++) begin
      trial      = {rem_next, shift_next[WORD_W-1]};
      shift_next = shift_next << 1;
      if (trial >= {1'b0, dsor}) begin
        trial = trial - {1'b0, dsor};
      end
      rem_next = trial[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CW'(DIV_CYCLES - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shift <= dividend;
      dsor  <= divisor;
      rem   <= '0;
    end else if (busy) begin
      shift <= shift_next;
      rem   <= rem_next;
    end
  end

  assign remainder = rem;

endmodule

[rtl/core/rmug_store.sv]
// ----------------------------------------------------------------------------
// rmug_store: permutation memory
// One write port and two registered read ports. A per-entry valid bit makes
// an entry that was never written since reset read as its own index.
// ----------------------------------------------------------------------------
module rmug_store
  import rmug_pkg::*;
#(
  parameter int DEPTH = DEFAULT_MAX_NODES,
  parameter int AW    = $clog2(DEFAULT_MAX_NODES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  output logic [AW-1:0] rd_data_a,
  output logic [AW-1:0] rd_data_b,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [AW-1:0] wr_data
);

  logic [AW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] written;

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= written[rd_addr_a] ? mem[rd_addr_a] : rd_addr_a;
      rd_data_b <= written[rd_addr_b] ? mem[rd_addr_b] : rd_addr_b;
    end
  end

endmodule

[rtl/core/rmug_datapath.sv]
// ----------------------------------------------------------------------------
// rmug_datapath: registers, store, remainder unit and result register
// Executes the commands of the controller: shuffle steps, pair reads, edge
// formatting and round bookkeeping.
// ----------------------------------------------------------------------------
module rmug_datapath
  import rmug_pkg::*;
#(
  parameter int MAX_NODES  = DEFAULT_MAX_NODES,
  parameter int MAX_ROUNDS = DEFAULT_MAX_ROUNDS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic [WORD_W-1:0]        random_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [NODE_FIELD_W-1:0]  first_node,
  output logic [NODE_FIELD_W-1:0]  second_node,
  output logic [EDGE_FIELD_W-1:0]  edge_number,
  output logic [ROUND_FIELD_W-1:0] round_number,
  output logic                     last_of_run,
  output logic                     generation_done,
  input  rmug_cmd_t                cmd,
  output rmug_status_t             st
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int RW  = $clog2(MAX_ROUNDS + 1);

  logic [NODE_CFG_W-1:0]   node_count;
  logic [ROUND_CFG_W-1:0]  round_count;
  logic [NCW-1:0]          n_eff;
  logic [RW-1:0]           r_eff;
  logic [NCW-1:0]          step_position;
  logic [RW-1:0]           round_index;
  logic                    odd_pending;
  logic [EDGE_FIELD_W-1:0] edge_counter;
  logic [NW-1:0]           pair_index;

  logic [NCW-1:0] step_clamped;
  logic [NW-1:0]  step_addr;
  logic [NCW-1:0] div_divisor;
  logic [NCW-1:0] div_rem;
  logic           div_done;
  logic [NCW:0]   swap_sum;
  logic [NW-1:0]  swap_addr;
  logic [NCW-1:0] half;
  logic           last_step;
  logic           last_pair;
  logic [NW-1:0]  pair_addr_a;
  logic [NW-1:0]  pair_addr_b;
  logic [NW-1:0]  rd_data_a;
  logic [NW-1:0]  rd_data_b;
  logic           rd_en;
  logic [NW-1:0]  rd_addr_a;
  logic [NW-1:0]  rd_addr_b;
  logic           wr_en;
  logic [NW-1:0]  wr_addr;
  logic [NW-1:0]  wr_data;
  logic [NW-1:0]  pair_lo;
  logic [NW-1:0]  pair_hi;
  logic [NCW-1:0] odd_first;
  logic           load;
  logic           close_round;
  logic           run_end;
  logic [RW-1:0]  round_inc;
  logic           gen_end;

  // Configuration registers, always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count  <= NODE_CFG_W'(10);
      round_count <= ROUND_CFG_W'(3);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NODE_COUNT:  node_count  <= cfg_data[NODE_CFG_W-1:0];
        REG_ROUND_COUNT: round_count <= cfg_data[ROUND_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Out-of-range settings are clamped to the supported span.
  always_comb begin
    if (32'(node_count) > MAX_NODES) begin
      n_eff = NCW'(MAX_NODES);
    end else if (node_count < NODE_CFG_W'(2)) begin
      n_eff = NCW'(2);
    end else begin
      n_eff = NCW'(node_count);
    end
    if (32'(round_count) > MAX_ROUNDS) begin
      r_eff = RW'(MAX_ROUNDS);
    end else if (round_count == '0) begin
      r_eff = RW'(1);
    end else begin
      r_eff = RW'(round_count);
    end
  end

  assign step_clamped = (step_position >= n_eff) ? n_eff - 1'b1 : step_position;
  assign step_addr    = NW'(step_clamped);
  assign div_divisor  = odd_pending ? n_eff - 1'b1 : n_eff - step_clamped;
  assign swap_sum     = {1'b0, div_rem} + {1'b0, step_clamped};
  assign swap_addr    = NW'(swap_sum);
  assign last_step    = (step_clamped == n_eff - 1'b1);
  assign half         = n_eff >> 1;
  assign last_pair    = (NCW'(pair_index) == half - 1'b1);
  assign pair_addr_a  = NW'({pair_index, 1'b0});
  assign pair_addr_b  = NW'({pair_index, 1'b1});

  rmug_divider #(
    .DW(NCW)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.accept),
    .dividend (random_word),
    .divisor  (div_divisor),
    .done     (div_done),
    .remainder(div_rem)
  );

  assign rd_en     = cmd.swap_rd | cmd.pair_rd;
  assign rd_addr_a = cmd.swap_rd ? step_addr : pair_addr_a;
  assign rd_addr_b = cmd.swap_rd ? swap_addr : pair_addr_b;
  assign wr_en     = cmd.swap_wr_first | cmd.swap_wr_second;
  assign wr_addr   = cmd.swap_wr_first ? step_addr : swap_addr;
  assign wr_data   = cmd.swap_wr_first ? rd_data_b : rd_data_a;

  rmug_store #(
    .DEPTH(MAX_NODES),
    .AW   (NW)
  ) u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (rd_en),
    .rd_addr_a(rd_addr_a),
    .rd_addr_b(rd_addr_b),
    .rd_data_a(rd_data_a),
    .rd_data_b(rd_data_b),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  assign pair_lo   = (rd_data_a < rd_data_b) ? rd_data_a : rd_data_b;
  assign pair_hi   = (rd_data_a < rd_data_b) ? rd_data_b : rd_data_a;
  assign odd_first = n_eff - 1'b1;

  // An odd node count leaves the round open until the extra edge is sent.
  assign load        = cmd.pair_load | cmd.odd_load;
  assign run_end     = cmd.odd_load | (cmd.pair_load & last_pair);
  assign close_round = cmd.odd_load | (cmd.pair_load & last_pair & ~n_eff[0]);
  assign round_inc   = round_index + 1'b1;
  assign gen_end     = (round_inc >= r_eff);

  always_ff @(posedge clk) begin
    if (rst) begin
      step_position <= '0;
      round_index   <= '0;
      odd_pending   <= 1'b0;
      edge_counter  <= '0;
      pair_index    <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.swap_wr_second) begin
        step_position <= last_step ? '0 : step_clamped + 1'b1;
        if (last_step) begin
          pair_index <= '0;
        end
      end
      if (cmd.pair_load && !last_pair) begin
        pair_index <= pair_index + 1'b1;
      end
      if (cmd.odd_load) begin
        odd_pending <= 1'b0;
      end else if (cmd.pair_load && last_pair && n_eff[0]) begin
        odd_pending <= 1'b1;
      end
      if (load) begin
        edge_counter <= (close_round && gen_end) ? '0 : edge_counter + 1'b1;
      end
      if (close_round) begin
        round_index <= gen_end ? '0 : round_inc;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      first_node      <= cmd.odd_load ? node_field(8'(odd_first)) : node_field(8'(pair_lo));
      second_node     <= cmd.odd_load ? node_field(8'(div_rem)) : node_field(8'(pair_hi));
      edge_number     <= edge_counter;
      round_number    <= round_field(8'(round_index));
      last_of_run     <= run_end;
      generation_done <= close_round & gen_end;
    end
  end

  assign st.div_done    = div_done;
  assign st.odd_pending = odd_pending;
  assign st.last_step   = last_step;
  assign st.last_pair   = last_pair;
  assign st.out_free    = ~out_valid | out_ready;

endmodule

[rtl/core/rmug_ctrl.sv]
// ----------------------------------------------------------------------------
// rmug_ctrl: sequencing state machine
// Takes one input item at a time and steps the datapath through the
// remainder, the store swap and the edge emission.
// ----------------------------------------------------------------------------
module rmug_ctrl
  import rmug_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  output logic         in_ready,
  input  rmug_status_t st,
  output rmug_cmd_t    cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DIV      = 3'd1;
  localparam logic [2:0] S_SWAP_RD  = 3'd2;
  localparam logic [2:0] S_SWAP_W1  = 3'd3;
  localparam logic [2:0] S_SWAP_W2  = 3'd4;
  localparam logic [2:0] S_PAIR_RD  = 3'd5;
  localparam logic [2:0] S_PAIR_OUT = 3'd6;
  localparam logic [2:0] S_ODD_OUT  = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (st.div_done) begin
          state_next = st.odd_pending ? S_ODD_OUT : S_SWAP_RD;
        end
      end
      S_SWAP_RD: begin
        cmd.swap_rd = 1'b1;
        state_next  = S_SWAP_W1;
      end
      S_SWAP_W1: begin
        cmd.swap_wr_first = 1'b1;
        state_next        = S_SWAP_W2;
      end
      S_SWAP_W2: begin
        cmd.swap_wr_second = 1'b1;
        state_next         = st.last_step ? S_PAIR_RD : S_IDLE;
      end
      S_PAIR_RD: begin
        cmd.pair_rd = 1'b1;
        state_next  = S_PAIR_OUT;
      end
      S_PAIR_OUT: begin
        if (st.out_free) begin
          cmd.pair_load = 1'b1;
          state_next    = st.last_pair ? S_IDLE : S_PAIR_RD;
        end
      end
      S_ODD_OUT: begin
        if (st.out_free) begin
          cmd.odd_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

[rtl/core/random_matching_union_generator_top.sv]
// ----------------------------------------------------------------------------
// random_matching_union_generator_top: random matching union generator
// Shuffles a persistent node permutation, one Fisher-Yates step per input word
// save odd-node words, and emits adjacent pairs of finished shuffles as edges.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   -------  ---------  -------------------  ----------------------------------
//   cfg      in         cfg_valid/cfg_ready  cfg_index, cfg_data
//   in       in         in_valid/in_ready    random_word
//   out      out        out_valid/out_ready  first_node, second_node,
//                                            edge_number, round_number,
//                                            last_of_run, generation_done
//
// After its transfer a shuffle step passes through the remainder unit (8 bits
// per cycle over the 32-bit word) and the read, swap and write-back on the
// store before the block is ready again. The last step of a round then walks
// the store, reading and emitting one pair after another; the odd-node edge
// needs only the remainder unit. Reset is synchronous; the store needs no
// clearing pass, since per-entry valid bits make unwritten entries read as
// their own index. A stalled result sits in the output register while the
// next item is accepted; emission waits only when a new edge finds it full.
// ----------------------------------------------------------------------------
module random_matching_union_generator_top
  import rmug_pkg::*;
#(
  parameter int MAX_NODES  = DEFAULT_MAX_NODES,
  parameter int MAX_ROUNDS = DEFAULT_MAX_ROUNDS
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CFG_INDEX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [WORD_W-1:0]        random_word,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [NODE_FIELD_W-1:0]  first_node,
  output logic [NODE_FIELD_W-1:0]  second_node,
  output logic [EDGE_FIELD_W-1:0]  edge_number,
  output logic [ROUND_FIELD_W-1:0] round_number,
  output logic                     last_of_run,
  output logic                     generation_done
);

  // Commands flow from the state machine to the datapath, status flows back.
  rmug_cmd_t    cmd;
  rmug_status_t st;

  // The controller owns the input handshake: one item is in flight at a time.
  rmug_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .st      (st),
    .cmd     (cmd)
  );

  // The datapath holds the configuration, the permutation store, the
  // remainder unit and the output register.
  rmug_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_ROUNDS(MAX_ROUNDS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .random_word    (random_word),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .first_node     (first_node),
    .second_node    (second_node),
    .edge_number    (edge_number),
    .round_number   (round_number),
    .last_of_run    (last_of_run),
    .generation_done(generation_done),
    .cmd            (cmd),
    .st             (st)
  );

  // An edge is only loaded when the output register can take it.
  assert property (@(posedge clk) disable iff (rst)
    (cmd.pair_load || cmd.odd_load) |-> st.out_free)
    else $error("edge loaded into a full output register");

  // After an input transfer the block is busy on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted twice in a row");

  // The end of a generation is always the end of a run.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && generation_done) |-> last_of_run)
    else $error("generation done without last of run");

  // Store writes never overlap an input transfer.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !(cmd.swap_wr_first || cmd.swap_wr_second))
    else $error("store written while accepting an item");

endmodule

[sim/random_matching_union_generator_top_tb.sv]
// ----------------------------------------------------------------------------
// random_matching_union_generator_top_tb: edge stream check of the generator
// Feeds random words through the shuffle and keeps a private copy of the
// permutation, step, round and edge counters. Every edge on the result
// channel is compared with the oldest predicted edge. Both channels idle at
// random, and the node and round counts change between phases.
// ----------------------------------------------------------------------------
import rmug_pkg::*;

typedef struct packed {
  logic [NODE_FIELD_W-1:0]  node_a;
  logic [NODE_FIELD_W-1:0]  node_b;
  logic [EDGE_FIELD_W-1:0]  edge_idx;
  logic [ROUND_FIELD_W-1:0] round_idx;
  logic                     item_last;
  logic                     gen_done;
} graph_edge_t;

// Shadow of the shuffle state. It turns accepted words into the edges they
// must produce and holds them until they show up on the result channel.
class shuffle_shadow;
  logic [NODE_FIELD_W-1:0]  perm [DEFAULT_MAX_NODES];
  logic [NODE_CFG_W-1:0]    node_cfg;
  logic [ROUND_CFG_W-1:0]   round_cfg;
  int unsigned              step_pos;
  int unsigned              round_pos;
  int unsigned              edge_count;
  bit                       odd_pending;
  graph_edge_t              edges_due [$];
  int                       errors;

  function new();
    int k;
    for (k = 0; k < DEFAULT_MAX_NODES; k++) perm[k] = NODE_FIELD_W'(k);
    node_cfg    = NODE_CFG_W'(10);
    round_cfg   = ROUND_CFG_W'(3);
    step_pos    = 0;
    round_pos   = 0;
    edge_count  = 0;
    odd_pending = 1'b0;
    errors      = 0;
  endfunction

  function int unsigned node_total();
    if (node_cfg < 2) return 2;
    if (node_cfg > DEFAULT_MAX_NODES) return DEFAULT_MAX_NODES;
    return int'(node_cfg);
  endfunction

  function int unsigned round_total();
    if (round_cfg < 1) return 1;
    if (round_cfg > DEFAULT_MAX_ROUNDS) return DEFAULT_MAX_ROUNDS;
    return int'(round_cfg);
  endfunction

  function void apply_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    if (idx == REG_NODE_COUNT) node_cfg = data[NODE_CFG_W-1:0];
    else round_cfg = data[ROUND_CFG_W-1:0];
  endfunction

  function graph_edge_t make_edge(int unsigned a, int unsigned b);
    graph_edge_t e;
    e.node_a    = a[NODE_FIELD_W-1:0];
    e.node_b    = b[NODE_FIELD_W-1:0];
    e.edge_idx  = edge_count[EDGE_FIELD_W-1:0];
    e.round_idx = round_pos[ROUND_FIELD_W-1:0];
    e.item_last = 1'b0;
    e.gen_done  = 1'b0;
    edge_count  = (edge_count + 1) % 512;
    return e;
  endfunction

  // Advances the round; returns 1 when the generation is complete.
  function bit close_round();
    round_pos++;
    if (round_pos >= round_total()) begin
      round_pos  = 0;
      edge_count = 0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function void take_word(logic [WORD_W-1:0] word);
    int unsigned n, i, r, j, a, b;
    logic [NODE_FIELD_W-1:0] t;
    graph_edge_t e;
    n = node_total();
    if (odd_pending) begin
      odd_pending = 1'b0;
      e = make_edge(n - 1, word % (n - 1));
      e.item_last = 1'b1;
      e.gen_done  = close_round();
      edges_due.push_back(e);
      return;
    end
    i = (step_pos >= n) ? n - 1 : step_pos;
    r = word % (n - i) + i;
    t = perm[r];
    perm[r] = perm[i];
    perm[i] = t;
    step_pos = i + 1;
    if (step_pos < n) return;
    step_pos = 0;
    for (j = 0; j < n / 2; j++) begin
      a = int'(perm[2 * j]);
      b = int'(perm[2 * j + 1]);
      e = (a < b) ? make_edge(a, b) : make_edge(b, a);
      if (j == n / 2 - 1) begin
        e.item_last = 1'b1;
        if (n % 2 == 1) odd_pending = 1'b1;
        else e.gen_done = close_round();
      end
      edges_due.push_back(e);
    end
  endfunction

  function void mismatch(string field, int unsigned want, int unsigned got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endfunction

  function void check_edge(graph_edge_t got);
    graph_edge_t want;
    if (edges_due.size() == 0) begin
      mismatch("unexpected edge transfer, pending edge count", 0, 1);
      return;
    end
    want = edges_due.pop_front();
    if (want.node_a != got.node_a) mismatch("first_node", want.node_a, got.node_a);
    if (want.node_b != got.node_b) mismatch("second_node", want.node_b, got.node_b);
    if (want.edge_idx != got.edge_idx) mismatch("edge_number", want.edge_idx, got.edge_idx);
    if (want.round_idx != got.round_idx)
      mismatch("round_number", want.round_idx, got.round_idx);
    if (want.item_last != got.item_last)
      mismatch("last_of_run", want.item_last, got.item_last);
    if (want.gen_done != got.gen_done)
      mismatch("generation_done", want.gen_done, got.gen_done);
  endfunction

  function int edges_left();
    return edges_due.size();
  endfunction

  function void close_out();
    if (edges_due.size() != 0) mismatch("edges never delivered", 0, edges_due.size());
  endfunction
endclass

module random_matching_union_generator_top_tb;

  // Idle wait at the end of settle(), long enough for an item that leaves no
  // edge behind to finish.
  localparam int SETTLE_CYCLES  = 40;
  localparam int DRAIN_LIMIT    = 100000;
  // Long receiver hold-off used to fill the output register and back up the
  // input channel.
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_PHASES  = 6;
  localparam int LARGE_PHASE    = 2;
  localparam int SMALL_ITEMS    = 12;
  localparam int LARGE_ITEMS    = 64;
  localparam int PRESSURE_ITEMS = 20;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CFG_INDEX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]    cfg_data;
  logic                     in_valid;
  logic                     in_ready;
  logic [WORD_W-1:0]        random_word;
  logic                     out_valid;
  logic                     out_ready;
  logic [NODE_FIELD_W-1:0]  first_node;
  logic [NODE_FIELD_W-1:0]  second_node;
  logic [EDGE_FIELD_W-1:0]  edge_number;
  logic [ROUND_FIELD_W-1:0] round_number;
  logic                     last_of_run;
  logic                     generation_done;

  shuffle_shadow shadow;

  // Traffic shaping: percentage of cycles in which the sender stays idle and
  // in which the receiver stalls. A hold-off is requested by bumping
  // hold_requested; the receiver process serves it on its own.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_requested = 0;
  int hold_served    = 0;

  random_matching_union_generator_top u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .random_word     (random_word),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .first_node      (first_node),
    .second_node     (second_node),
    .edge_number     (edge_number),
    .round_number    (round_number),
    .last_of_run     (last_of_run),
    .generation_done (generation_done)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Both channels are sampled at the rising edge, where every bench-driven
  // signal has been stable since the falling edge. The input transfer is
  // recorded first so that the edge queue always leads the result channel.
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if (in_valid && in_ready) shadow.take_word(random_word);
      if (out_valid && out_ready)
        shadow.check_edge(graph_edge_t'({first_node, second_node, edge_number,
                                         round_number, last_of_run, generation_done}));
    end
  end

  // Receiver: random stalls at the requested rate, or a long hold-off when
  // one has been asked for. The hold-off is counted here in clock cycles.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requested) begin
        hold_served = hold_requested;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Writes one register. Only called while nothing is in flight, so the
  // shadow can take the new value at the transfer.
  task automatic cfg_write(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    shadow.apply_reg(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Offers one word and returns at the rising edge of its transfer. in_valid
  // is left high, so back-to-back words keep it asserted; the next call or
  // settle() decides its value at the following falling edge.
  task automatic send_word(input logic [WORD_W-1:0] w);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    random_word <= w;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops the sender, waits for every predicted edge, then gives a step
  // that emits nothing time to finish before the block is treated as idle.
  task automatic settle();
    int guard;
    guard = 0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (shadow.edges_left() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly full-range words, with the all-zero, all-one and small values
  // mixed in so that the remainder sees its corner dividends.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(15))
      0:       return '0;
      1:       return '1;
      2:       return WORD_W'($urandom_range(255));
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int p;
    int k;
    int items;
    logic [CFG_DATA_W-1:0] node_val;

    shadow      = new();
    rst         = 1'b1;
    cfg_valid   = 1'b0;
    cfg_index   = REG_NODE_COUNT;
    cfg_data    = '0;
    in_valid    = 1'b0;
    random_word = '0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part, light traffic shaping throughout.
    send_idle_pct  = 25;
    recv_stall_pct = 25;

    // Node count 0 and round count 0 act as two nodes and one round: every
    // second word closes a round and the generation with a single edge.
    cfg_write(REG_NODE_COUNT, 7'd0);
    cfg_write(REG_ROUND_COUNT, 7'd0);
    send_word('0);
    send_word('1);
    send_word('1);
    send_word('0);
    settle();

    // Fifteen rounds (the upper data bits are ignored), then lowering the round
    // count to one in the middle of the generation ends it at the next round end.
    cfg_write(REG_ROUND_COUNT, 7'h7F);
    send_word('0);
    send_word('1);
    settle();
    cfg_write(REG_ROUND_COUNT, 7'h71);
    send_word(32'h8000_0000);
    send_word('1);
    settle();

    // Three nodes: three steps and a pair edge, then a word for the odd-node edge.
    cfg_write(REG_NODE_COUNT, 7'd3);
    cfg_write(REG_ROUND_COUNT, 7'd2);
    send_word('0);
    send_word('1);
    send_word(32'h8000_0000);
    send_word('1);
    settle();

    // Node count lowered mid-round: two steps into five nodes, then a count
    // of one (two nodes) forces a self swap at the last position.
    cfg_write(REG_NODE_COUNT, 7'd5);
    send_word('1);
    send_word(32'h0000_0001);
    settle();
    cfg_write(REG_NODE_COUNT, 7'd1);
    send_word(32'h0000_0007);
    settle();

    // Odd-node edge left pending, then emitted with a count above the
    // maximum, which acts as the largest node count.
    cfg_write(REG_NODE_COUNT, 7'd3);
    send_word('0);
    send_word('0);
    send_word('0);
    settle();
    cfg_write(REG_NODE_COUNT, 7'd127);
    cfg_write(REG_ROUND_COUNT, 7'd15);
    send_word('1);
    settle();

    // Random phases. Each one takes a fresh setting and one of four traffic
    // shapes: none, a mostly idle sender, a mostly stalled receiver, and
    // both idling now and then. One phase sends one word per node at the largest
    // node count, so it can reach the longest burst of edges from a single word.
    for (p = 0; p < RANDOM_PHASES; p++) begin
      if (p == LARGE_PHASE) begin
        node_val = CFG_DATA_W'(DEFAULT_MAX_NODES);
        items    = LARGE_ITEMS;
      end else begin
        case ($urandom_range(7))
          0:       node_val = CFG_DATA_W'($urandom_range(1));
          1:       node_val = CFG_DATA_W'($urandom_range(127, 65));
          default: node_val = CFG_DATA_W'($urandom_range(12, 2));
        endcase
        items = SMALL_ITEMS;
      end
      cfg_write(REG_NODE_COUNT, node_val);
      cfg_write(REG_ROUND_COUNT, CFG_DATA_W'($urandom()));
      case (p % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 88;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 88;
        end
        default: begin
          send_idle_pct  = 25;
          recv_stall_pct = 25;
        end
      endcase
      for (k = 0; k < items; k++) send_word(pick_word());
      settle();
    end

    // Back-pressure: with two nodes every second word makes an edge. The
    // receiver holds off for a long stretch while words keep coming, so the
    // output register fills and the block has to stall its input channel.
    cfg_write(REG_NODE_COUNT, 7'd2);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_requested = hold_requested + 1;
    for (k = 0; k < PRESSURE_ITEMS; k++) send_word(pick_word());

    // Drain everything, then judge the run.
    settle();
    shadow.close_out();
    if (shadow.errors == 0) begin
      $display("random_matching_union_generator_top_tb OK");
    end else begin
      $display("random_matching_union_generator_top_tb NOT OK");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #400000;
    $display("random_matching_union_generator_top_tb NOT OK");
    $finish;
  end

endmodule

[sim.f]
rtl/core/rmug_pkg.sv
rtl/core/rmug_divider.sv
rtl/core/rmug_store.sv
rtl/core/rmug_datapath.sv
rtl/core/rmug_ctrl.sv
rtl/core/random_matching_union_generator_top.sv
sim/random_matching_union_generator_top_tb.sv
